// ===== rtl/core/cilc_pkg.sv =====
// ----------------------------------------------------------------------------
// cilc_pkg
// shared types, codes and default sizes of the cluster item list compactor
// ----------------------------------------------------------------------------
package cilc_pkg;

    localparam int DEF_ITEM_DEPTH     = 4096;
    localparam int DEF_LIST_ADDR_BITS = 24;
    localparam int DEF_MAX_LIGHTS     = 1023;
    localparam int DEF_MAX_PROBES     = 4095;

    localparam int DECAL_CAP = 1023;
    localparam int MAX_POS   = 4096;

    localparam int REQ_W   = 2;
    localparam int BLK_W   = 7;
    localparam int MASK_W  = 32;
    localparam int ADDR_W  = 24;
    localparam int DATA_W  = 32;
    localparam int LCNT_W  = 10;
    localparam int DCNT_W  = 10;
    localparam int PCNT_W  = 12;
    localparam int POS_W   = 12;
    localparam int CLUS_W  = 16;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_LIGHT = 2'd0,
        REQ_DECAL = 2'd1,
        REQ_PROBE = 2'd2,
        REQ_FRAME = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MERGE
    } t_state;

    localparam logic KIND_ITEM   = 1'b0;
    localparam logic KIND_HEADER = 1'b1;

    localparam logic [1:0] REG_NUM_LIGHTS = 2'd0;
    localparam logic [1:0] REG_NUM_DECALS = 2'd1;
    localparam logic [1:0] REG_NUM_PROBES = 2'd2;

    localparam logic [DATA_W-1:0] DECAL_FIELD = 32'h000F_FC00;
    localparam logic [DATA_W-1:0] LOW_FIELDS  = 32'h000F_FFFF;

endpackage

// ===== rtl/core/cilc_if.sv =====
// ----------------------------------------------------------------------------
// cilc_if
// valid/ready channels for mask words in and list transactions out
// ----------------------------------------------------------------------------
interface cilc_in_if;
    logic                         valid;
    logic                         ready;
    logic [cilc_pkg::REQ_W-1:0]   req_type;
    logic [cilc_pkg::BLK_W-1:0]   block_index;
    logic [cilc_pkg::MASK_W-1:0]  mask_word;
    logic                         end_of_cluster;

    modport source (output valid, req_type, block_index, mask_word, end_of_cluster,
                    input ready);
    modport sink (input valid, req_type, block_index, mask_word, end_of_cluster,
                  output ready);
endinterface

interface cilc_out_if;
    logic                         valid;
    logic                         ready;
    logic                         out_kind;
    logic [cilc_pkg::ADDR_W-1:0]  address;
    logic [cilc_pkg::DATA_W-1:0]  data_word;
    logic [cilc_pkg::ADDR_W-1:0]  list_offset_out;
    logic                         overflow;
    logic                         last;

    modport source (output valid, out_kind, address, data_word, list_offset_out, overflow,
                    last, input ready);
    modport sink (input valid, out_kind, address, data_word, list_offset_out, overflow,
                  last, output ready);
endinterface

// ===== rtl/core/cilc_ram.sv =====
// ----------------------------------------------------------------------------
// cilc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cilc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cluster_item_list_compactor_unit.sv =====
// ----------------------------------------------------------------------------
// cluster_item_list_compactor_unit
// turns per-cluster membership masks into packed item list writes and headers
// ----------------------------------------------------------------------------
// first result: registered from the scan state, or from the merge state after
//   an item buffer ram read when that first set bit merges into a stored word
// set bits: one scan step each (light, fresh word or dropped) or a ram read
//   in scan and then a merge (decal or probe merged into a stored word);
//   output back-pressure can hold either; a new mask word is taken only in idle
// reset: synchronous, clears counts, offset, cluster number, config and the
//   output valid; the item buffer ram is not cleared
module cluster_item_list_compactor_unit #(
    parameter int ITEM_DEPTH     = cilc_pkg::DEF_ITEM_DEPTH,
    parameter int LIST_ADDR_BITS = cilc_pkg::DEF_LIST_ADDR_BITS,
    parameter int MAX_LIGHTS     = cilc_pkg::DEF_MAX_LIGHTS,
    parameter int MAX_PROBES     = cilc_pkg::DEF_MAX_PROBES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cilc_in_if.sink                       i_in,
    cilc_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cilc_pkg::PADDR_W-1:0]  paddr,
    input  logic [cilc_pkg::PDATA_W-1:0]  pwdata,
    output logic [cilc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import cilc_pkg::*;

    localparam int MEM_DEPTH = (ITEM_DEPTH < MAX_POS) ? ITEM_DEPTH : MAX_POS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int AMASK_W   = (LIST_ADDR_BITS < ADDR_W) ? LIST_ADDR_BITS : ADDR_W;
    localparam logic [ADDR_W:0] ADDR_MASK_X = (25'd1 << AMASK_W) - 25'd1;
    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_MASK_X[ADDR_W-1:0];
    localparam int LIGHT_LIM_I = (MAX_LIGHTS < ITEM_DEPTH) ? MAX_LIGHTS : ITEM_DEPTH;
    localparam int DECAL_LIM_I = (DECAL_CAP < ITEM_DEPTH) ? DECAL_CAP : ITEM_DEPTH;
    localparam int PROBE_LIM_I = (MAX_PROBES < ITEM_DEPTH) ? MAX_PROBES : ITEM_DEPTH;
    localparam logic [POS_W-1:0] LIGHT_LIM = POS_W'(LIGHT_LIM_I);
    localparam logic [POS_W-1:0] DECAL_LIM = POS_W'(DECAL_LIM_I);
    localparam logic [POS_W-1:0] PROBE_LIM = POS_W'(PROBE_LIM_I);

    t_state              r_state, n_state;
    t_req_type           r_type;
    logic [BLK_W-1:0]    r_blk;
    logic [MASK_W-1:0]   r_mask;
    logic                r_eoc;
    logic [LCNT_W-1:0]   r_light_cnt;
    logic [DCNT_W-1:0]   r_decal_cnt;
    logic [PCNT_W-1:0]   r_probe_cnt;
    logic [ADDR_W-1:0]   r_list_offset;
    logic [CLUS_W-1:0]   r_cluster;
    logic [LCNT_W-1:0]   r_num_lights;
    logic [DCNT_W-1:0]   r_num_decals;
    logic [PCNT_W-1:0]   r_num_probes;

    logic                r_out_valid;
    logic                r_out_kind;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [DATA_W-1:0]   r_out_data;
    logic [ADDR_W-1:0]   r_out_offset;
    logic                r_out_ovf;
    logic                r_out_last;

    logic                w_in_acc;
    t_req_type           w_in_type;
    logic [PCNT_W-1:0]   w_in_limit;
    logic [PCNT_W:0]     w_blk_sum;
    logic [PCNT_W-5:0]   w_blk_lim;
    logic                w_blk_ok;
    logic                w_cfg_we;

    logic                w_slot;
    logic [MASK_W-1:0]   w_low;
    logic [MASK_W-1:0]   w_rest;
    logic [4:0]          w_bit;
    logic [POS_W-1:0]    w_idx;
    logic [POS_W-1:0]    w_pos;
    logic [POS_W-1:0]    w_lim;
    logic                w_drop;
    logic [LCNT_W-1:0]   w_used;
    logic                w_need_rd;
    logic [DATA_W-1:0]   w_fresh;
    logic [DATA_W-1:0]   w_merged;
    logic [DATA_W-1:0]   w_word;
    logic [DATA_W-1:0]   w_rdata;
    logic [ADDR_W-1:0]   w_item_addr;
    logic [DATA_W-1:0]   w_counts;
    logic [PCNT_W-1:0]   w_most;

    logic                w_mem_re;
    logic                w_mem_we;
    logic                w_load;
    logic                w_step;
    logic                w_bump;
    logic                w_hdr;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_NUM_LIGHTS: prdata = PDATA_W'(r_num_lights);
            REG_NUM_DECALS: prdata = PDATA_W'(r_num_decals);
            REG_NUM_PROBES: prdata = PDATA_W'(r_num_probes);
            default:        prdata = '0;
        endcase
    end

    // input decode
    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_in_type  = t_req_type'(i_in.req_type);

    always_comb begin
        case (w_in_type)
            REQ_LIGHT: w_in_limit = PCNT_W'(r_num_lights);
            REQ_DECAL: w_in_limit = PCNT_W'(r_num_decals);
            default:   w_in_limit = r_num_probes;
        endcase
    end

    assign w_blk_sum = {1'b0, w_in_limit} + (PCNT_W+1)'(31);
    assign w_blk_lim = w_blk_sum[PCNT_W:5];
    assign w_blk_ok  = {1'b0, i_in.block_index} < w_blk_lim;

    // lowest set bit
    assign w_low  = r_mask & (~r_mask + 32'd1);
    assign w_rest = r_mask & (r_mask - 32'd1);

    always_comb begin
        w_bit = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (w_low[i]) begin
                w_bit = w_bit | 5'(i);
            end
        end
    end

    assign w_idx  = {r_blk, w_bit};
    assign w_used = (r_light_cnt > r_decal_cnt) ? r_light_cnt : r_decal_cnt;

    always_comb begin
        case (r_type)
            REQ_LIGHT: begin
                w_pos     = POS_W'(r_light_cnt);
                w_lim     = LIGHT_LIM;
                w_need_rd = 1'b0;
                w_fresh   = DATA_W'(w_idx[9:0]);
                w_merged  = w_fresh;
            end
            REQ_DECAL: begin
                w_pos     = POS_W'(r_decal_cnt);
                w_lim     = DECAL_LIM;
                w_need_rd = r_decal_cnt < r_light_cnt;
                w_fresh   = {12'd0, w_idx[9:0], 10'd0};
                w_merged  = (w_rdata & ~DECAL_FIELD) | w_fresh;
            end
            default: begin
                w_pos     = r_probe_cnt;
                w_lim     = PROBE_LIM;
                w_need_rd = r_probe_cnt < PCNT_W'(w_used);
                w_fresh   = {w_idx, 20'd0};
                w_merged  = (w_rdata & LOW_FIELDS) | w_fresh;
            end
        endcase
    end

    assign w_drop      = w_pos >= w_lim;
    assign w_word      = (r_state == S_MERGE) ? w_merged : w_fresh;
    assign w_item_addr = (r_list_offset + ADDR_W'(w_pos)) & ADDR_MASK;
    assign w_counts    = {r_probe_cnt, r_decal_cnt, r_light_cnt};

    always_comb begin
        w_most = PCNT_W'(w_used);
        if (r_probe_cnt > w_most) begin
            w_most = r_probe_cnt;
        end
    end

    assign w_slot = !r_out_valid || o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_in_type != REQ_FRAME) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_mask == '0) begin
                    if (!r_eoc || w_slot) begin
                        n_state = S_IDLE;
                    end
                end else if (!w_drop && w_need_rd) begin
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (w_slot) begin
                    n_state = S_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        w_mem_re = 1'b0;
        w_mem_we = 1'b0;
        w_load   = 1'b0;
        w_step   = 1'b0;
        w_bump   = 1'b0;
        w_hdr    = 1'b0;
        case (r_state)
            S_SCAN: begin
                if (r_mask != '0) begin
                    if (w_drop) begin
                        w_load = w_slot;
                        w_step = w_slot;
                    end else if (w_need_rd) begin
                        w_mem_re = 1'b1;
                    end else begin
                        w_mem_we = w_slot;
                        w_load   = w_slot;
                        w_step   = w_slot;
                        w_bump   = w_slot;
                    end
                end else if (r_eoc) begin
                    w_load = w_slot;
                    w_hdr  = w_slot;
                end
            end
            S_MERGE: begin
                w_mem_we = w_slot;
                w_load   = w_slot;
                w_step   = w_slot;
                w_bump   = w_slot;
            end
            default: begin
                w_mem_re = 1'b0;
            end
        endcase
    end

    cilc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_item_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_pos[MEM_AW-1:0]),
        .i_wdata (w_word),
        .i_re    (w_mem_re),
        .i_raddr (w_pos[MEM_AW-1:0]),
        .o_rdata (w_rdata)
    );

    // control and cluster state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_light_cnt   <= '0;
            r_decal_cnt   <= '0;
            r_probe_cnt   <= '0;
            r_list_offset <= '0;
            r_cluster     <= '0;
            r_num_lights  <= '0;
            r_num_decals  <= '0;
            r_num_probes  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_we) begin
                case (paddr[3:2])
                    REG_NUM_LIGHTS: r_num_lights <= pwdata[LCNT_W-1:0];
                    REG_NUM_DECALS: r_num_decals <= pwdata[DCNT_W-1:0];
                    REG_NUM_PROBES: r_num_probes <= pwdata[PCNT_W-1:0];
                    default: ;
                endcase
            end

            if (w_in_acc && w_in_type == REQ_FRAME) begin
                r_list_offset <= '0;
                r_cluster     <= '0;
                r_light_cnt   <= '0;
                r_decal_cnt   <= '0;
                r_probe_cnt   <= '0;
            end else if (w_hdr) begin
                r_list_offset <= (r_list_offset + ADDR_W'(w_most)) & ADDR_MASK;
                r_cluster     <= r_cluster + 16'd1;
                r_light_cnt   <= '0;
                r_decal_cnt   <= '0;
                r_probe_cnt   <= '0;
            end else if (w_bump) begin
                case (r_type)
                    REQ_LIGHT: r_light_cnt <= r_light_cnt + 10'd1;
                    REQ_DECAL: r_decal_cnt <= r_decal_cnt + 10'd1;
                    default:   r_probe_cnt <= r_probe_cnt + 12'd1;
                endcase
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // mask word and output payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_type <= w_in_type;
            r_blk  <= i_in.block_index;
            r_mask <= w_blk_ok ? i_in.mask_word : '0;
            r_eoc  <= i_in.end_of_cluster;
        end else if (w_step) begin
            r_mask <= w_rest;
        end

        if (w_load) begin
            r_out_kind   <= w_hdr ? KIND_HEADER : KIND_ITEM;
            r_out_addr   <= w_hdr ? ADDR_W'(r_cluster) : w_item_addr;
            r_out_data   <= w_hdr ? w_counts : (w_drop ? '0 : w_word);
            r_out_offset <= r_list_offset;
            r_out_ovf    <= !w_hdr && w_drop;
            r_out_last   <= w_hdr || (w_rest == '0 && !r_eoc);
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.out_kind        = r_out_kind;
    assign o_out.address         = r_out_addr;
    assign o_out.data_word       = r_out_data;
    assign o_out.list_offset_out = r_out_offset;
    assign o_out.overflow        = r_out_ovf;
    assign o_out.last            = r_out_last;

    // checks
    a_read_then_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_re |=> r_state == S_MERGE)
        else $error("ram read not followed by merge");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> !w_mem_re)
        else $error("ram read and write in the same cycle");

    a_count_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        POS_W'(r_light_cnt) <= LIGHT_LIM && POS_W'(r_decal_cnt) <= DECAL_LIM
        && r_probe_cnt <= PROBE_LIM)
        else $error("item count beyond its limit");

    a_drop_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ovf |-> r_out_kind == KIND_ITEM && r_out_data == '0)
        else $error("dropped item carries data");

endmodule
